// ===== design/necenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necenc_pkg
// Shared types, constants and helpers of the NEC infrared frame encoder.
// ----------------------------------------------------------------------------
package necenc_pkg;

    localparam int CODE_W  = 16;
    localparam int WORD_W  = 32;
    localparam int TICK_W  = 12;
    localparam int unsigned TICK_MAX = (1 << TICK_W) - 1;

    localparam int UNIT_TIME_DEF = 1125;
    localparam int TICK_TIME_DEF = 32;

    // frame layout in units
    localparam int PRE_MARK_UNITS    = 16;
    localparam int PRE_SPACE_UNITS   = 8;
    localparam int BIT_MARK_UNITS    = 1;
    localparam int ZERO_SPACE_UNITS  = 1;
    localparam int ONE_SPACE_UNITS   = 3;
    localparam int TRAIL_MARK_UNITS  = 1;
    localparam int TRAIL_SPACE_UNITS = 72;

    localparam int PAIRS_PER_FRAME = WORD_W + 2;
    localparam int IDX_W           = $clog2(PAIRS_PER_FRAME);
    localparam logic [IDX_W-1:0] TRAIL_IDX = IDX_W'(PAIRS_PER_FRAME - 1);

    // code queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

    typedef struct packed {
        logic [TICK_W-1:0] mark;
        logic [TICK_W-1:0] space;
        logic              last;
    } t_pair;

    // address, inverted address, command, inverted command; sent lsb first
    function automatic logic [WORD_W-1:0] nec_word(input logic [CODE_W-1:0] code);
        logic [7:0] addr;
        logic [7:0] cmd;
        addr = code[15:8];
        cmd  = code[7:0];
        return {~cmd, cmd, ~addr, addr};
    endfunction

    function automatic logic [TICK_W-1:0] sat_ticks(input int unsigned v);
        return (v > TICK_MAX) ? TICK_W'(TICK_MAX) : v[TICK_W-1:0];
    endfunction

endpackage

// ===== design/necenc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necenc_front
// Accepts codes, forms the 32-bit NEC word and pushes it into the queue.
// ----------------------------------------------------------------------------
module necenc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [necenc_pkg::CODE_W-1:0]  i_ir_code,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output logic [necenc_pkg::WORD_W-1:0]  o_q_word
);
    import necenc_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [WORD_W-1:0] r_word;
    logic              in_xfer;

    assign o_in_stall = r_valid && i_q_full;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_word   = r_word;

    always_comb begin
        n_valid = r_valid;
        if (in_xfer) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_word <= nec_word(i_ir_code);
        end
    end

endmodule

// ===== design/necenc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necenc_queue
// Small register queue of NEC words between the front and the back.
// ----------------------------------------------------------------------------
module necenc_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [necenc_pkg::WORD_W-1:0]  i_word,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic                           o_nonempty,
    output logic [necenc_pkg::WORD_W-1:0]  o_word
);
    import necenc_pkg::*;

    logic [WORD_W-1:0] r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full     = (r_count == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_word     = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

// ===== design/necenc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necenc_back
// Frame sequencer: pops a word and emits its 34 mark/space pairs, one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module necenc_back #(
    parameter int UNIT_TIME = necenc_pkg::UNIT_TIME_DEF,
    parameter int TICK_TIME = necenc_pkg::TICK_TIME_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_nonempty,
    input  logic [necenc_pkg::WORD_W-1:0]  i_q_word,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output necenc_pkg::t_pair              o_pair
);
    import necenc_pkg::*;

    localparam int TickDiv = (TICK_TIME < 1) ? 1 : TICK_TIME;
    localparam logic [TICK_W-1:0] PreMark    =
        sat_ticks(PRE_MARK_UNITS * UNIT_TIME / TickDiv);
    localparam logic [TICK_W-1:0] PreSpace   =
        sat_ticks(PRE_SPACE_UNITS * UNIT_TIME / TickDiv);
    localparam logic [TICK_W-1:0] BitMark    =
        sat_ticks(BIT_MARK_UNITS * UNIT_TIME / TickDiv);
    localparam logic [TICK_W-1:0] ZeroSpace  =
        sat_ticks(ZERO_SPACE_UNITS * UNIT_TIME / TickDiv);
    localparam logic [TICK_W-1:0] OneSpace   =
        sat_ticks(ONE_SPACE_UNITS * UNIT_TIME / TickDiv);
    localparam logic [TICK_W-1:0] TrailMark  =
        sat_ticks(TRAIL_MARK_UNITS * UNIT_TIME / TickDiv);
    localparam logic [TICK_W-1:0] TrailSpace =
        sat_ticks(TRAIL_SPACE_UNITS * UNIT_TIME / TickDiv);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              r_out_valid;
    logic              n_out_valid;
    t_pair             r_pair;
    t_pair             n_pair;
    logic              load_en;

    // output register may refill when empty or being drained
    assign load_en     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_pair      = r_pair;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_word      = r_word;
        n_out_valid = r_out_valid && i_out_stall;
        n_pair      = r_pair;
        o_q_pop     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // preamble is loaded into the output register in the same cycle the word is popped
                if (load_en && i_q_nonempty) begin
                    o_q_pop     = 1'b1;
                    n_word      = i_q_word;
                    n_idx       = IDX_W'(1);
                    n_state     = ST_RUN;
                    n_out_valid = 1'b1;
                    n_pair      = '{mark: PreMark, space: PreSpace, last: 1'b0};
                end
            end
            ST_RUN: begin
                if (load_en) begin
                    n_out_valid = 1'b1;
                    if (r_idx == TRAIL_IDX) begin
                        n_pair  = '{mark: TrailMark, space: TrailSpace, last: 1'b1};
                        n_state = ST_IDLE;
                    end else begin
                        n_pair = '{mark: BitMark,
                                   space: r_word[0] ? OneSpace : ZeroSpace,
                                   last: 1'b0};
                        n_word = r_word >> 1;
                        n_idx  = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_pair <= n_pair;
    end

endmodule

// ===== design/nec_ir_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_encoder
// Expands a 16-bit address/command code into a 34-pair NEC infrared frame.
// ----------------------------------------------------------------------------
// Each accepted code gives 34 mark/space pairs in transmitter ticks: the
// preamble, 32 bit pairs (address, inverted address, command, inverted
// command, lsb first) and a trailer flagged by o_last. The sequencer emits
// one pair per cycle while the output is not stalled, and frames follow
// each other with no gap; that sequencer sets the sustained code rate.
// A taken code passes the input register and the queue before its preamble
// is loaded. An input register and a two-entry queue hold up to three codes
// ahead of the frame in progress. Durations are fixed at elaboration from
// UNIT_TIME and TICK_TIME and saturate at 4095 ticks.
module nec_ir_frame_encoder #(
    parameter int UNIT_TIME = necenc_pkg::UNIT_TIME_DEF,
    parameter int TICK_TIME = necenc_pkg::TICK_TIME_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [necenc_pkg::CODE_W-1:0]  i_ir_code,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [necenc_pkg::TICK_W-1:0]  o_mark_ticks,
    output logic [necenc_pkg::TICK_W-1:0]  o_space_ticks,
    output logic                           o_last
);
    import necenc_pkg::*;

    logic              q_push;
    logic [WORD_W-1:0] q_wr_word;
    logic              q_full;
    logic              q_pop;
    logic              q_nonempty;
    logic [WORD_W-1:0] q_rd_word;
    t_pair             pair;

    necenc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_ir_code  (i_ir_code),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_word   (q_wr_word)
    );

    necenc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_word     (q_wr_word),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_word     (q_rd_word)
    );

    necenc_back #(
        .UNIT_TIME (UNIT_TIME),
        .TICK_TIME (TICK_TIME)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_word     (q_rd_word),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pair       (pair)
    );

    assign o_mark_ticks  = pair.mark;
    assign o_space_ticks = pair.space;
    assign o_last        = pair.last;

endmodule

// ===== bench/nec_ir_frame_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_encoder_tb
// Self-checking bench for the NEC infrared frame encoder.
// ----------------------------------------------------------------------------
// Codes go in through the input channel. For each accepted code the bench
// builds the 34 expected mark/space pairs and queues them. Every pair that
// comes out is checked field by field against the oldest queued pair. Both
// sides idle at random, and there is also a stretch of back-to-back traffic,
// a long output hold that fills the block, and a drain pause on the sender.
// ----------------------------------------------------------------------------
module nec_ir_frame_encoder_tb;
    import necenc_pkg::*;

    localparam int UNIT_TIME = UNIT_TIME_DEF;
    localparam int TICK_TIME = TICK_TIME_DEF;
    localparam int HOLD_CYCLES = 400;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              code_valid = 1'b0;
    logic              code_stall;
    logic [CODE_W-1:0] ir_code = '0;
    logic              pair_valid;
    logic              pair_stall = 1'b0;
    logic [TICK_W-1:0] mark_ticks;
    logic [TICK_W-1:0] space_ticks;
    logic              pair_last;

    t_pair pending_pairs[$];
    int    error_count = 0;
    int    codes_sent = 0;
    int    pairs_checked = 0;
    bit    tx_idle = 1'b1;
    bit    rx_idle = 1'b1;
    int    rx_hold_cycles = 0;

    nec_ir_frame_encoder #(
        .UNIT_TIME(UNIT_TIME),
        .TICK_TIME(TICK_TIME)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(code_valid),
        .o_in_stall(code_stall),
        .i_ir_code(ir_code),
        .o_out_valid(pair_valid),
        .i_out_stall(pair_stall),
        .o_mark_ticks(mark_ticks),
        .o_space_ticks(space_ticks),
        .o_last(pair_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // duration of n units in ticks, truncated, saturating at the field width
    function automatic logic [TICK_W-1:0] dur_ticks(input int unsigned units);
        longint unsigned t;
        longint unsigned div;
        div = (TICK_TIME == 0) ? 1 : TICK_TIME;
        t = (longint'(units) * longint'(UNIT_TIME)) / div;
        return (t > TICK_MAX) ? TICK_W'(TICK_MAX) : t[TICK_W-1:0];
    endfunction

    function automatic void build_frame(input logic [CODE_W-1:0] code);
        logic [WORD_W-1:0] word;
        t_pair             p;
        word = {~code[7:0], code[7:0], ~code[15:8], code[15:8]};
        p.mark  = dur_ticks(PRE_MARK_UNITS);
        p.space = dur_ticks(PRE_SPACE_UNITS);
        p.last  = 1'b0;
        pending_pairs.push_back(p);
        for (int i = 0; i < WORD_W; i++) begin
            p.mark  = dur_ticks(BIT_MARK_UNITS);
            p.space = dur_ticks(word[i] ? ONE_SPACE_UNITS : ZERO_SPACE_UNITS);
            p.last  = 1'b0;
            pending_pairs.push_back(p);
        end
        p.mark  = dur_ticks(TRAIL_MARK_UNITS);
        p.space = dur_ticks(TRAIL_SPACE_UNITS);
        p.last  = 1'b1;
        pending_pairs.push_back(p);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 30) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // one code transfer; valid stays up after the transfer until the next call
    task automatic send_code(input logic [CODE_W-1:0] code);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0) begin
            code_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        code_valid = 1'b1;
        ir_code = code;
        do @(posedge clk); while (code_stall);
        build_frame(code);
        codes_sent++;
    endtask

    task automatic wait_for_frames();
        @(negedge clk);
        code_valid = 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
    endtask

    // receiver: random hold before each pair while rx_idle is set, plus an optional long hold
    initial begin
        int unsigned n;
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                pair_stall = 1'b1;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            n = rx_idle ? $urandom_range(0, 9) : 0;
            if (n > 0) begin
                pair_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            pair_stall = 1'b0;
            do @(posedge clk); while (!pair_valid);
        end
    end

    always @(posedge clk) begin
        t_pair exp_pair;
        if (rst_n && pair_valid && !pair_stall) begin
            if (pending_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair mark=%0d space=%0d last=%0b",
                                          mark_ticks, space_ticks, pair_last));
            end else begin
                exp_pair = pending_pairs.pop_front();
                if (mark_ticks !== exp_pair.mark)
                    report_mismatch($sformatf("pair %0d mark %0d, expected %0d",
                                              pairs_checked, mark_ticks, exp_pair.mark));
                if (space_ticks !== exp_pair.space)
                    report_mismatch($sformatf("pair %0d space %0d, expected %0d",
                                              pairs_checked, space_ticks, exp_pair.space));
                if (pair_last !== exp_pair.last)
                    report_mismatch($sformatf("pair %0d last %0b, expected %0b",
                                              pairs_checked, pair_last, exp_pair.last));
                pairs_checked++;
            end
        end
    end

    // all-zero and all-one codes, complementary patterns, walking one
    task automatic test_directed();
        logic [CODE_W-1:0] corner[6] = '{16'h0000, 16'hFFFF, 16'h00FF,
                                         16'hFF00, 16'hAAAA, 16'h5555};
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (corner[i]) send_code(corner[i]);
        for (int b = 0; b < CODE_W; b++) send_code(CODE_W'(1) << b);
        wait_for_frames();
    endtask

    task automatic test_random_gaps(input int count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (count) send_code(CODE_W'($urandom_range(0, 65535)));
        wait_for_frames();
    endtask

    task automatic test_streaming(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count) send_code(CODE_W'($urandom_range(0, 65535)));
        wait_for_frames();
    endtask

    // receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_output_hold(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (count) send_code(CODE_W'($urandom_range(0, 65535)));
        wait_for_frames();
    endtask

    // sender stops until every queued pair has come out, then resumes
    task automatic test_sender_pause(input int bursts, input int per_burst);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (bursts) begin
            repeat (per_burst) send_code(CODE_W'($urandom_range(0, 65535)));
            wait_for_frames();
        end
    endtask

    task automatic test_mixed(input int blocks, input int per_block);
        repeat (blocks) begin
            tx_idle = 1'($urandom_range(0, 1));
            rx_idle = 1'($urandom_range(0, 1));
            repeat (per_block) send_code(CODE_W'($urandom_range(0, 65535)));
        end
        wait_for_frames();
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_gaps(140);
        test_streaming(60);
        test_output_hold(12);
        test_sender_pause(4, 5);
        test_mixed(8, 16);

        repeat (50) @(posedge clk);
        if (pending_pairs.size() != 0)
            report_mismatch($sformatf("%0d pairs never arrived", pending_pairs.size()));

        $display("%0d codes sent, %0d pairs checked, %0d mismatches", codes_sent,
                 pairs_checked, error_count);
        $display("covered corner codes, random idling, back-to-back traffic, a %0d-cycle %s",
                 HOLD_CYCLES, "output hold and drained sender pauses");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: %0d pairs still pending", pending_pairs.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/necenc_pkg.sv
design/necenc_front.sv
design/necenc_queue.sv
design/necenc_back.sv
design/nec_ir_frame_encoder.sv
bench/nec_ir_frame_encoder_tb.sv
